// ===== rtl/grayscale_morphology_window_defines.svh =====
// Assertion macros shared by the checker of the grayscale morphology window.
// No dependencies; the user must have i_clk and i_rst_n in scope.
`ifndef GRAYSCALE_MORPHOLOGY_WINDOW_DEFINES_SVH
`define GRAYSCALE_MORPHOLOGY_WINDOW_DEFINES_SVH

// Consequent in the next cycle, checked also while reset is held.
`define GMW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

// Consequent in the next cycle, switched off while reset is held.
`define GMW_ASSERT_NEXT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/gmw_pkg.sv =====
// Shared types and constants of the grayscale morphology window.
// No dependencies; used by every module of the block.
`default_nettype none

package gmw_pkg;

    localparam int PIXEL_W     = 8;
    localparam int POS_W       = 10;
    localparam int CFG_DIM_W   = 11;
    localparam int RADIUS_W    = 2;
    localparam int MASK_W      = 49;
    localparam int MASK_IDX_W  = 6;
    localparam int MODE_W      = 2;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 49;
    localparam int OUT_DATA_W  = 32;
    localparam int MAX_HEIGHT  = 1024;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_RADIUS = 3;

    localparam logic [CFG_DIM_W-1:0] RST_IMG_WIDTH    = 11'd640;
    localparam logic [CFG_DIM_W-1:0] RST_IMG_HEIGHT   = 11'd480;
    localparam logic [RADIUS_W-1:0]  RST_RADIUS       = 2'd1;
    localparam logic [MASK_W-1:0]    RST_ELEMENT_MASK = 49'd186;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_IMG_WIDTH    = 3'd0,
        REG_IMG_HEIGHT   = 3'd1,
        REG_RADIUS       = 3'd2,
        REG_ELEMENT_MASK = 3'd3,
        REG_MODE         = 3'd4
    } t_reg_idx;

    typedef enum logic [MODE_W-1:0] {
        MODE_EROSION  = 2'd0,
        MODE_DILATION = 2'd1,
        MODE_GRADIENT = 2'd2
    } t_mode;

    // Window stage controls: shift in a new column, register row reductions.
    typedef struct packed {
        logic shift;
        logic reduce;
    } t_win_ctrl;

endpackage

`default_nettype wire

// ===== rtl/grayscale_morphology_window.sv =====
// Top level of the grayscale morphology window (erosion, dilation, gradient).
// Depends on gmw_pkg, gmw_ram and gmw_window.
//
// Usage: pixels enter in raster order on the s_ stream, one request per
// pixel, with the pixel in s_tdata and a frame start flag in s_tuser. Once a
// pixel completes a full window of side 2r+1 the block produces one result on
// the m_ stream for the window centre: value, centre row and centre column in
// m_tdata, and m_tlast high on the final result of a frame. Border pixels give
// no result. Registers are to be written through the plain i_cfg_ port
// only while the block is idle; the block itself does not enforce this.
// They take effect for the next request. Throughput is one pixel per clock
// while the receiver takes results and the clearing pass is over; the four
// stages, in order, are line store read, window shift, row reduction and
// final reduction. After reset the line stores are cleared, one column per
// cycle; s_tready stays low during that pass. When the receiver stalls, the
// result holds in the output register while the stages behind it go on
// filling, so up to three more requests are taken before s_tready drops.
`default_nettype none

module grayscale_morphology_window #(
    parameter int MAX_WIDTH  = gmw_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = gmw_pkg::DEF_MAX_RADIUS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [gmw_pkg::PIXEL_W-1:0]       s_tdata,   // [7:0] pixel
    input  logic                              s_tuser,   // [0] frame_start
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] out_value, [17:8] out_row, [27:18] out_col, [31:28] zero
    output logic [gmw_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tlast,   // last_of_frame
    // Configuration write port
    input  logic                              i_cfg_wr_en,
    input  logic [gmw_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [gmw_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    import gmw_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int CMPW   = (WW > CFG_DIM_W) ? WW : CFG_DIM_W;
    localparam int COLX   = (CW > POS_W) ? CW : POS_W;
    localparam int NLINES = 2 * MAX_RADIUS;
    localparam int WSIDE  = NLINES + 1;
    localparam int LW     = $clog2(NLINES);

    // Position and flags of a request as it travels down the stages.
    typedef struct packed {
        logic             emit;
        logic             last;
        logic [POS_W-1:0] crow;
        logic [POS_W-1:0] ccol;
    } t_pos;

    // Configuration registers
    logic [CFG_DIM_W-1:0] r_img_width;
    logic [CFG_DIM_W-1:0] r_img_height;
    logic [RADIUS_W-1:0]  r_radius;
    logic [MASK_W-1:0]    r_element_mask;
    logic [MODE_W-1:0]    r_mode;

    // Effective limits after saturation
    logic [WW-1:0]        w_eff;
    logic [CFG_DIM_W-1:0] h_eff;
    logic [RADIUS_W-1:0]  r_eff;
    logic [2:0]           two_r;

    // Position counters and line store clearing
    logic [CW-1:0]    r_col;
    logic [POS_W-1:0] r_row;
    logic [LW-1:0]    r_mod;
    logic [CW-1:0]    n_col;
    logic [POS_W-1:0] n_row;
    logic [LW-1:0]    n_mod;
    logic             r_clear;
    logic [CW-1:0]    r_clr_addr;

    // Stage 0 position of the incoming request
    logic [CW-1:0]        col0;
    logic [POS_W-1:0]     row0;
    logic [LW-1:0]        mod0;
    logic [CW-1:0]        col1;
    logic [CFG_DIM_W-1:0] row1;
    logic [LW-1:0]        mod1;
    logic [POS_W-1:0]     row2;
    logic [LW-1:0]        mod2;
    logic [WW-1:0]        col_inc;
    logic [CFG_DIM_W-1:0] row_inc;
    logic [COLX-1:0]      ccol_x;
    t_pos                 pos0;

    // Handshake and stage valids
    logic accept;
    logic adv_1;
    logic adv_w;
    logic adv_2;
    logic adv_o;
    logic r_v1;
    logic r_vw;
    logic r_v2;
    logic r_ov;

    // Stage payloads
    logic [PIXEL_W-1:0]    r_px1;
    logic [LW-1:0]         r_mod1;
    t_pos                  r_pos1;
    t_pos                  r_posw;
    t_pos                  r_pos2;
    logic [OUT_DATA_W-1:0] r_odata;
    logic                  r_olast;

    // Line store and window
    logic [NLINES-1:0][PIXEL_W-1:0] w_line_rd;
    logic [WSIDE-1:0][PIXEL_W-1:0]  w_col_new;
    logic [LW:0]                    line_sel;
    t_win_ctrl                      w_ctrl;
    logic [WSIDE-1:0][PIXEL_W-1:0]  w_row_min;
    logic [WSIDE-1:0][PIXEL_W-1:0]  w_row_max;
    logic [WSIDE-1:0]               w_row_any;

    // Final reduction
    logic [PIXEL_W-1:0] red_min;
    logic [PIXEL_W-1:0] red_max;
    logic               red_any;
    logic [PIXEL_W-1:0] red_grad;
    logic [PIXEL_W-1:0] red_value;

    // ---------------------------------------------------------------------
    // Configuration registers; writes to unknown indexes are dropped.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width    <= RST_IMG_WIDTH;
            r_img_height   <= RST_IMG_HEIGHT;
            r_radius       <= RST_RADIUS;
            r_element_mask <= RST_ELEMENT_MASK;
            r_mode         <= MODE_EROSION;
        end else if (i_cfg_wr_en) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_IMG_WIDTH: begin
                    r_img_width <= i_cfg_wdata[CFG_DIM_W-1:0];
                end
                REG_IMG_HEIGHT: begin
                    r_img_height <= i_cfg_wdata[CFG_DIM_W-1:0];
                end
                REG_RADIUS: begin
                    r_radius <= i_cfg_wdata[RADIUS_W-1:0];
                end
                REG_ELEMENT_MASK: begin
                    r_element_mask <= i_cfg_wdata[MASK_W-1:0];
                end
                REG_MODE: begin
                    r_mode <= i_cfg_wdata[MODE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // A zero width or height counts as one; oversize values saturate, as
    // does a radius beyond what the window was built for.
    always_comb begin
        if (r_img_width == '0) begin
            w_eff = WW'(1);
        end else if (CMPW'(r_img_width) > CMPW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_img_width);
        end
        if (r_img_height == '0) begin
            h_eff = CFG_DIM_W'(1);
        end else if (r_img_height > CFG_DIM_W'(MAX_HEIGHT)) begin
            h_eff = CFG_DIM_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_img_height;
        end
        if (r_radius > RADIUS_W'(MAX_RADIUS)) begin
            r_eff = RADIUS_W'(MAX_RADIUS);
        end else begin
            r_eff = r_radius;
        end
        two_r = {r_eff, 1'b0};
    end

    // ---------------------------------------------------------------------
    // Stage 0: position of the incoming pixel. The counters are re-checked
    // against the limits first, so that a smaller width or height written
    // since the last pixel wraps them at once. r_mod follows row modulo the
    // number of line stores and picks the store that takes this pixel.
    // ---------------------------------------------------------------------
    always_comb begin
        col0 = s_tuser ? '0 : r_col;
        row0 = s_tuser ? '0 : r_row;
        mod0 = s_tuser ? '0 : r_mod;

        if (WW'(col0) >= w_eff) begin
            col1 = '0;
            row1 = {1'b0, row0} + CFG_DIM_W'(1);
            mod1 = (mod0 == LW'(NLINES - 1)) ? '0 : mod0 + LW'(1);
        end else begin
            col1 = col0;
            row1 = {1'b0, row0};
            mod1 = mod0;
        end

        if (row1 >= h_eff) begin
            row2 = '0;
            mod2 = '0;
        end else begin
            row2 = row1[POS_W-1:0];
            mod2 = mod1;
        end

        ccol_x    = COLX'(col1) - COLX'(r_eff);
        pos0.emit = (row2 >= POS_W'(two_r)) && (col1 >= CW'(two_r));
        pos0.last = ({1'b0, row2} == h_eff - CFG_DIM_W'(1))
                    && (WW'(col1) == w_eff - WW'(1));
        pos0.crow = row2 - POS_W'(r_eff);
        pos0.ccol = ccol_x[POS_W-1:0];

        col_inc = WW'(col1) + WW'(1);
        row_inc = {1'b0, row2} + CFG_DIM_W'(1);
        if (col_inc >= w_eff) begin
            n_col = '0;
            if (row_inc >= h_eff) begin
                n_row = '0;
                n_mod = '0;
            end else begin
                n_row = row_inc[POS_W-1:0];
                n_mod = (mod2 == LW'(NLINES - 1)) ? '0 : mod2 + LW'(1);
            end
        end else begin
            n_col = col_inc[CW-1:0];
            n_row = row2;
            n_mod = mod2;
        end
    end

    // ---------------------------------------------------------------------
    // Flow control. Each stage moves on when it is empty or the stage after
    // it moves; only the output register looks at m_tready.
    // ---------------------------------------------------------------------
    assign adv_o    = !r_ov || m_tready;
    assign adv_2    = !r_v2 || adv_o;
    assign adv_w    = !r_vw || adv_2;
    assign adv_1    = !r_v1 || adv_w;
    assign s_tready = !r_clear && adv_1;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear    <= 1'b1;
            r_clr_addr <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_mod      <= '0;
            r_v1       <= 1'b0;
            r_vw       <= 1'b0;
            r_v2       <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (r_clear) begin
                r_clr_addr <= r_clr_addr + CW'(1);
                if (r_clr_addr == CW'(MAX_WIDTH - 1)) begin
                    r_clear <= 1'b0;
                end
            end
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
                r_mod <= n_mod;
            end
            if (adv_1) begin
                r_v1 <= accept;
            end
            if (adv_w) begin
                r_vw <= r_v1;
            end
            if (adv_2) begin
                r_v2 <= r_vw;
            end
            if (adv_o) begin
                r_ov <= r_v2 && r_pos2.emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px1  <= s_tdata;
            r_mod1 <= mod2;
            r_pos1 <= pos0;
        end
        if (adv_w && r_v1) begin
            r_posw <= r_pos1;
        end
        if (adv_2 && r_vw) begin
            r_pos2 <= r_posw;
        end
        if (adv_o && r_v2) begin
            r_odata <= {{(OUT_DATA_W - PIXEL_W - 2 * POS_W){1'b0}},
                        r_pos2.ccol, r_pos2.crow, red_value};
            r_olast <= r_pos2.last;
        end
    end

    // ---------------------------------------------------------------------
    // Line stores: one RAM per buffered row, all read at the column of the
    // incoming pixel. The store of the current row is written in the same
    // cycle; it reads first, so it still returns the row NLINES lines up.
    // The clearing pass after reset zeroes every store, column by column.
    // ---------------------------------------------------------------------
    for (genvar gi = 0; gi < NLINES; gi++) begin : g_line
        logic               wr_en;
        logic [CW-1:0]      wr_addr;
        logic [PIXEL_W-1:0] wr_data;

        assign wr_en   = r_clear || (accept && (mod2 == LW'(gi)));
        assign wr_addr = r_clear ? r_clr_addr : col1;
        assign wr_data = r_clear ? '0 : s_tdata;

        gmw_ram #(
            .WIDTH (PIXEL_W),
            .DEPTH (MAX_WIDTH)
        ) u_line_ram (
            .i_clk     (i_clk),
            .i_wr_en   (wr_en),
            .i_wr_addr (wr_addr),
            .i_wr_data (wr_data),
            .i_rd_en   (accept),
            .i_rd_addr (col1),
            .o_rd_data (w_line_rd[gi])
        );
    end

    // Stage 1: the new window column. Row d above the newest sits in store
    // (row - d) mod NLINES.
    always_comb begin
        line_sel     = '0;
        w_col_new[0] = r_px1;
        for (int d = 1; d < WSIDE; d++) begin
            line_sel = (LW + 1)'(r_mod1) + (LW + 1)'(NLINES - d);
            if (line_sel >= (LW + 1)'(NLINES)) begin
                line_sel = line_sel - (LW + 1)'(NLINES);
            end
            w_col_new[d] = w_line_rd[line_sel[LW-1:0]];
        end
    end

    assign w_ctrl.shift  = adv_w && r_v1;
    assign w_ctrl.reduce = adv_2 && r_vw;

    gmw_window #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_window (
        .i_clk          (i_clk),
        .i_ctrl         (w_ctrl),
        .i_col          (w_col_new),
        .i_radius       (r_eff),
        .i_element_mask (r_element_mask),
        .o_row_min      (w_row_min),
        .o_row_max      (w_row_max),
        .o_row_any      (w_row_any)
    );

    // ---------------------------------------------------------------------
    // Final reduction over the row results and mode select. An empty
    // element leaves minimum 255 and maximum 0, and the gradient is forced
    // to zero. An undefined mode code behaves as the gradient.
    // ---------------------------------------------------------------------
    always_comb begin
        red_min = '1;
        red_max = '0;
        red_any = 1'b0;
        for (int d = 0; d < WSIDE; d++) begin
            if (w_row_min[d] < red_min) begin
                red_min = w_row_min[d];
            end
            if (w_row_max[d] > red_max) begin
                red_max = w_row_max[d];
            end
            red_any = red_any | w_row_any[d];
        end
        red_grad = red_any ? (red_max - red_min) : '0;
        case (t_mode'(r_mode))
            MODE_EROSION: begin
                red_value = red_min;
            end
            MODE_DILATION: begin
                red_value = red_max;
            end
            MODE_GRADIENT: begin
                red_value = red_grad;
            end
            default: begin
                red_value = red_grad;
            end
        endcase
    end

    assign m_tvalid = r_ov;
    assign m_tdata  = r_odata;
    assign m_tlast  = r_olast;

endmodule

`default_nettype wire

// ===== rtl/gmw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on gmw_pkg for its default sizes only.
`default_nettype none

module gmw_ram #(
    parameter int WIDTH = gmw_pkg::PIXEL_W,
    parameter int DEPTH = gmw_pkg::DEF_MAX_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Read-first: a read and a write to one address return the old word.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/gmw_window.sv =====
// Square pixel window, structuring element decode and per-row min/max stage.
// Depends on gmw_pkg.
`default_nettype none

module gmw_window #(
    parameter int MAX_RADIUS = gmw_pkg::DEF_MAX_RADIUS
) (
    input  logic                                          i_clk,
    input  gmw_pkg::t_win_ctrl                            i_ctrl,
    input  logic [2*MAX_RADIUS:0][gmw_pkg::PIXEL_W-1:0]   i_col,
    input  logic [gmw_pkg::RADIUS_W-1:0]                  i_radius,
    input  logic [gmw_pkg::MASK_W-1:0]                    i_element_mask,
    output logic [2*MAX_RADIUS:0][gmw_pkg::PIXEL_W-1:0]   o_row_min,
    output logic [2*MAX_RADIUS:0][gmw_pkg::PIXEL_W-1:0]   o_row_max,
    output logic [2*MAX_RADIUS:0]                         o_row_any
);

    import gmw_pkg::*;

    localparam int WSIDE = 2 * MAX_RADIUS + 1;

    // r_win[d][e] is the pixel d rows above and e columns left of the newest.
    logic [WSIDE-1:0][WSIDE-1:0][PIXEL_W-1:0] r_win;
    logic [WSIDE-1:0][WSIDE-1:0]              r_emask;
    logic [WSIDE-1:0][WSIDE-1:0]              n_emask;
    logic [WSIDE-1:0][PIXEL_W-1:0]            r_row_min;
    logic [WSIDE-1:0][PIXEL_W-1:0]            r_row_max;
    logic [WSIDE-1:0]                         r_row_any;
    logic [WSIDE-1:0][PIXEL_W-1:0]            n_row_min;
    logic [WSIDE-1:0][PIXEL_W-1:0]            n_row_max;
    logic [WSIDE-1:0]                         n_row_any;
    logic [2:0]                               two_r;
    logic [3:0]                               side;
    logic [MASK_IDX_W-1:0]                    bit_idx;

    // Map each window cell onto its mask bit; bit k*side+l is window row k,
    // column l counted from the top left, i.e. cell (2r-k, 2r-l) here.
    always_comb begin
        two_r   = {i_radius, 1'b0};
        side    = {1'b0, two_r} + 4'd1;
        bit_idx = '0;
        n_emask = '0;
        for (int d = 0; d < WSIDE; d++) begin
            for (int e = 0; e < WSIDE; e++) begin
                if (d <= int'(two_r) && e <= int'(two_r)) begin
                    bit_idx = MASK_IDX_W'((int'(two_r) - d) * int'(side)
                                          + (int'(two_r) - e));
                    n_emask[d][e] = i_element_mask[bit_idx];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_emask <= n_emask;
        if (i_ctrl.shift) begin
            for (int d = 0; d < WSIDE; d++) begin
                for (int e = WSIDE - 1; e > 0; e--) begin
                    r_win[d][e] <= r_win[d][e-1];
                end
                r_win[d][0] <= i_col[d];
            end
        end
    end

    // Unselected cells leave the neutral values, so empty rows drop out.
    always_comb begin
        for (int d = 0; d < WSIDE; d++) begin
            n_row_min[d] = '1;
            n_row_max[d] = '0;
            n_row_any[d] = 1'b0;
            for (int e = 0; e < WSIDE; e++) begin
                if (r_emask[d][e]) begin
                    if (r_win[d][e] < n_row_min[d]) begin
                        n_row_min[d] = r_win[d][e];
                    end
                    if (r_win[d][e] > n_row_max[d]) begin
                        n_row_max[d] = r_win[d][e];
                    end
                    n_row_any[d] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.reduce) begin
            r_row_min <= n_row_min;
            r_row_max <= n_row_max;
            r_row_any <= n_row_any;
        end
    end

    assign o_row_min = r_row_min;
    assign o_row_max = r_row_max;
    assign o_row_any = r_row_any;

endmodule

`default_nettype wire

// ===== rtl/gmw_checker.sv =====
// Port-level checks of the grayscale morphology window, bound to the top.
// Depends on gmw_pkg and grayscale_morphology_window_defines.svh.
`default_nettype none
`include "grayscale_morphology_window_defines.svh"

module gmw_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [gmw_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tlast
);

    // Reset empties the result register.
    `GMW_ASSERT_NEXT(a_reset_no_result, !i_rst_n, !m_tvalid, "result valid after reset")

    // Reset starts the line store clearing pass, which refuses requests.
    `GMW_ASSERT_NEXT(a_reset_clears, !i_rst_n, !s_tready, "request taken during clear")

    // A stalled result stays put until it is taken.
    `GMW_ASSERT_NEXT_RST(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

endmodule

bind grayscale_morphology_window gmw_checker u_gmw_checker (.*);

`default_nettype wire
